FILE: hw/rtl/vpss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vanishing-point stroke snap package
// Shared codes, constants and sequencer states for the stroke snap block.
// ----------------------------------------------------------------------------
package vpss_pkg;

  // Action codes of an input request
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_SHOT  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SNAP_EN  = 3'd0;
  localparam logic [2:0] CFG_PT_CNT   = 3'd1;
  localparam logic [2:0] CFG_VP1_X    = 3'd2;
  localparam logic [2:0] CFG_VP1_Y    = 3'd3;
  localparam logic [2:0] CFG_VP2_X    = 3'd4;
  localparam logic [2:0] CFG_VP2_Y    = 3'd5;
  localparam logic [2:0] CFG_VP3_X    = 3'd6;
  localparam logic [2:0] CFG_VP3_Y    = 3'd7;

  localparam logic [1:0] MAX_POINTS = 2'd3;

  // Squared distances in Q8 units: 6 px near radius, 4 px point skip
  localparam logic [63:0] NEAR_SQ = 64'd2359296;
  localparam logic [63:0] SKIP_SQ = 64'd1048576;

  // Q1.16 unit length (vertical direction)
  localparam logic signed [17:0] UNIT_ONE = 18'sd65536;

  // Last iteration of the bit-serial root and divider
  localparam logic [4:0] SQRT_LAST = 5'd31;
  localparam logic [4:0] DIV_LAST  = 5'd17;

  // Output saturation bounds
  localparam logic signed [33:0] SAT_MAX = 34'sd8388607;
  localparam logic signed [33:0] SAT_MIN = -34'sd8388608;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_NR0, ST_NR1, ST_NR2, ST_NR3,
    ST_CAND,
    ST_CS0, ST_CS1, ST_CS2, ST_CS3,
    ST_SQRT,
    ST_DV_INIT, ST_DV_RUN,
    ST_CR0, ST_CR1, ST_CR2, ST_CR3,
    ST_VERT,
    ST_PJ0, ST_PJ1, ST_PJ2, ST_PJ3,
    ST_PM0, ST_PM1, ST_PM2, ST_PM3,
    ST_WB
  } state_e;

endpackage

FILE: hw/rtl/vanishing_point_stroke_snap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vanishing-point stroke snap
// Snaps stylus positions onto rays toward up to three vanishing points.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i / in_stall_o) takes one request: an action, a
//  position and an anchor. Output channel (out_valid_o / out_stall_i) returns
//  one result per request: snapped x/y and the lock flag.
//  Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i while
//  the block is idle.
//  Begin and pass-through requests go straight to writeback; a stroke
//  point near the anchor snaps to it, and a locked one is projected onto
//  the held direction. A direction search visits each configured
//  vanishing point: a point farther than 4 px runs a bit-serial square
//  root and two bit-serial divides, and a nearer one is skipped.
//  One request is in flight at a time; in_stall_o is low only when idle.
//  A finished result waits in the output register while out_stall_i is
//  high, and the next request can be taken meanwhile.
//  Reset clears configuration, the stroke anchor, the lock and the output
//  valid.
// ----------------------------------------------------------------------------
module vanishing_point_stroke_snap_top
  import vpss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  // input requests
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [23:0] pos_x_i,
  input  logic signed [23:0] pos_y_i,
  input  logic signed [23:0] anchor_x_i,
  input  logic signed [23:0] anchor_y_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_x_o,
  output logic signed [23:0] out_y_o,
  output logic               is_locked_o
);

  state_e state_q, state_d;

  // configuration and stroke state
  logic               snap_en_q;
  logic [1:0]         pt_cnt_q;
  logic signed [23:0] vp_x_q [3];
  logic signed [23:0] vp_y_q [3];
  logic signed [23:0] anc_x_q, anc_y_q;
  logic               lock_q;
  logic signed [17:0] dir_x_q, dir_y_q;

  // request working registers
  logic [1:0]         act_q;
  logic signed [23:0] px_q, py_q, wa_x_q, wa_y_q;
  logic signed [24:0] rx_q, ry_q, dx_q, dy_q;
  logic [1:0]         idx_q;
  logic signed [51:0] prod_q;
  logic signed [63:0] acc_q;
  logic [43:0]        best_q;
  logic               have_q;
  logic signed [17:0] bux_q, buy_q, ux_q, uy_q;
  logic [63:0]        sq_op_q;
  logic [33:0]        sq_rem_q;
  logic [31:0]        sq_root_q;
  logic [4:0]         cnt_q;
  logic [31:0]        dv_rem_q;
  logic [17:0]        dv_sh_q;
  logic               dv_y_q;
  logic [43:0]        tmag_q;
  logic               tneg_q, comp_q;
  logic signed [23:0] res_x_q, res_y_q;
  logic signed [23:0] out_x_q, out_y_q;
  logic               out_lock_q, out_vld_q;

  // control
  logic               in_acc, wb_load, active;
  logic [1:0]         n_pts;
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] mul_p;

  assign active = snap_en_q && (pt_cnt_q != 2'd0);
  assign n_pts  = (pt_cnt_q > MAX_POINTS) ? MAX_POINTS : pt_cnt_q;
  assign in_acc = in_valid_i && !in_stall_o;

  // shared multiplier, registered
  assign mul_p = mul_a * mul_b;

  // candidate point read
  logic signed [23:0] vp_sel_x, vp_sel_y;
  always_comb begin
    unique case (idx_q)
      2'd0: begin vp_sel_x = vp_x_q[0]; vp_sel_y = vp_y_q[0]; end
      2'd1: begin vp_sel_x = vp_x_q[1]; vp_sel_y = vp_y_q[1]; end
      2'd2: begin vp_sel_x = vp_x_q[2]; vp_sel_y = vp_y_q[2]; end
      default: begin vp_sel_x = '0; vp_sel_y = '0; end
    endcase
  end

  // accumulator helpers
  logic signed [63:0] prod_ext;
  logic [63:0]        acc_mag;
  logic [24:0]        rx_mag;
  logic [43:0]        vdist;
  assign prod_ext = {{12{prod_q[51]}}, prod_q};
  assign acc_mag  = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign rx_mag   = rx_q[24] ? 25'(-rx_q) : 25'(rx_q);
  assign vdist    = {3'b000, rx_mag, 16'h0000};

  // bit-serial square root step (two operand bits per cycle)
  logic [35:0] sq_rw, sq_tr;
  logic        sq_ge;
  logic [33:0] sq_rem_d;
  assign sq_rw    = {sq_rem_q, sq_op_q[63:62]};
  assign sq_tr    = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_rw >= sq_tr;
  assign sq_rem_d = sq_ge ? 34'(sq_rw - sq_tr) : sq_rw[33:0];

  // bit-serial restoring divide step, divisor is the root
  logic signed [24:0] dv_c;
  logic [24:0]        dv_cmag;
  logic [47:0]        dv_num;
  logic [32:0]        dv_rw;
  logic               dv_ge;
  logic [31:0]        dv_rem_d;
  logic [17:0]        dv_q_d;
  logic signed [17:0] dv_u;
  assign dv_c     = dv_y_q ? dy_q : dx_q;
  assign dv_cmag  = dv_c[24] ? 25'(-dv_c) : 25'(dv_c);
  assign dv_num   = {dv_cmag, 23'h0} + 48'(sq_root_q[31:1]);
  assign dv_rw    = {dv_rem_q, dv_sh_q[17]};
  assign dv_ge    = dv_rw >= {1'b0, sq_root_q};
  assign dv_rem_d = dv_ge ? 32'(dv_rw - {1'b0, sq_root_q}) : dv_rw[31:0];
  assign dv_q_d   = {dv_sh_q[16:0], dv_ge};
  assign dv_u     = dv_c[24] ? -$signed(dv_q_d) : $signed(dv_q_d);

  // candidate compare
  logic cr_take, vert_take;
  assign cr_take   = !have_q || (acc_mag[43:0] < best_q);
  assign vert_take = !have_q || (vdist < best_q);

  // projection component
  logic signed [17:0] bsel;
  logic [17:0]        bmag;
  logic [63:0]        pm_rnd;
  logic [31:0]        pm_m;
  logic               pm_neg;
  logic signed [23:0] wsel;
  logic signed [33:0] pm_sum;
  logic signed [23:0] pm_sat;
  assign bsel   = comp_q ? buy_q : bux_q;
  assign bmag   = bsel[17] ? 18'(-bsel) : 18'(bsel);
  assign pm_rnd = acc_q + 64'h0000_0000_8000_0000;
  assign pm_m   = pm_rnd[63:32];
  assign pm_neg = bsel[17] ^ tneg_q;
  assign wsel   = comp_q ? wa_y_q : wa_x_q;
  assign pm_sum = {{10{wsel[23]}}, wsel}
                + (pm_neg ? -$signed({2'b00, pm_m}) : $signed({2'b00, pm_m}));
  always_comb begin
    priority if (pm_sum > SAT_MAX) pm_sat = SAT_MAX[23:0];
    else if (pm_sum < SAT_MIN)     pm_sat = SAT_MIN[23:0];
    else                           pm_sat = pm_sum[23:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_BEGIN) state_d = ST_WB;
          else if ((action_i == ACT_POINT || action_i == ACT_SHOT) && active)
            state_d = ST_PREP;
          else state_d = ST_WB;
        end
      end
      ST_PREP: begin
        if (act_q == ACT_POINT && lock_q) state_d = ST_PJ0;
        else if (act_q == ACT_POINT)      state_d = ST_NR0;
        else                              state_d = ST_CAND;
      end
      ST_NR0:  state_d = ST_NR1;
      ST_NR1:  state_d = ST_NR2;
      ST_NR2:  state_d = ST_NR3;
      ST_NR3:  state_d = (acc_q < $signed(NEAR_SQ)) ? ST_WB : ST_CAND;
      ST_CAND: state_d = (idx_q < n_pts) ? ST_CS0 : ST_VERT;
      ST_CS0:  state_d = ST_CS1;
      ST_CS1:  state_d = ST_CS2;
      ST_CS2:  state_d = ST_CS3;
      ST_CS3:  state_d = (acc_q < $signed(SKIP_SQ)) ? ST_CAND : ST_SQRT;
      ST_SQRT: if (cnt_q == SQRT_LAST) state_d = ST_DV_INIT;
      ST_DV_INIT: state_d = ST_DV_RUN;
      ST_DV_RUN: if (cnt_q == DIV_LAST) state_d = dv_y_q ? ST_CR0 : ST_DV_INIT;
      ST_CR0:  state_d = ST_CR1;
      ST_CR1:  state_d = ST_CR2;
      ST_CR2:  state_d = ST_CR3;
      ST_CR3:  state_d = ST_CAND;
      ST_VERT: state_d = ST_PJ0;
      ST_PJ0:  state_d = ST_PJ1;
      ST_PJ1:  state_d = ST_PJ2;
      ST_PJ2:  state_d = ST_PJ3;
      ST_PJ3:  state_d = ST_PM0;
      ST_PM0:  state_d = ST_PM1;
      ST_PM1:  state_d = ST_PM2;
      ST_PM2:  state_d = ST_PM3;
      ST_PM3:  state_d = comp_q ? ST_WB : ST_PM0;
      ST_WB:   if (wb_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs: handshake and multiplier operands
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    wb_load    = (state_q == ST_WB) && (!out_vld_q || !out_stall_i);
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_q)
      ST_NR0: begin mul_a = 26'(rx_q); mul_b = 26'(rx_q); end
      ST_NR1: begin mul_a = 26'(ry_q); mul_b = 26'(ry_q); end
      ST_CS0: begin mul_a = 26'(dx_q); mul_b = 26'(dx_q); end
      ST_CS1: begin mul_a = 26'(dy_q); mul_b = 26'(dy_q); end
      ST_CR0: begin mul_a = 26'(rx_q); mul_b = 26'(uy_q); end
      ST_CR1: begin mul_a = 26'(ry_q); mul_b = 26'(ux_q); end
      ST_PJ0: begin mul_a = 26'(rx_q); mul_b = 26'(bux_q); end
      ST_PJ1: begin mul_a = 26'(ry_q); mul_b = 26'(buy_q); end
      ST_PM0: begin
        mul_a = $signed({8'h00, bmag});
        mul_b = $signed({4'h0, tmag_q[21:0]});
      end
      ST_PM1: begin
        mul_a = $signed({8'h00, bmag});
        mul_b = $signed({4'h0, tmag_q[43:22]});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // control state: configuration, stroke anchor, lock, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      snap_en_q <= 1'b0;
      pt_cnt_q  <= '0;
      vp_x_q[0] <= '0; vp_x_q[1] <= '0; vp_x_q[2] <= '0;
      vp_y_q[0] <= '0; vp_y_q[1] <= '0; vp_y_q[2] <= '0;
      anc_x_q   <= '0;
      anc_y_q   <= '0;
      lock_q    <= 1'b0;
      dir_x_q   <= '0;
      dir_y_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SNAP_EN: snap_en_q <= cfg_data_i[0];
          CFG_PT_CNT:  pt_cnt_q  <= cfg_data_i[1:0];
          CFG_VP1_X:   vp_x_q[0] <= cfg_data_i;
          CFG_VP1_Y:   vp_y_q[0] <= cfg_data_i;
          CFG_VP2_X:   vp_x_q[1] <= cfg_data_i;
          CFG_VP2_Y:   vp_y_q[1] <= cfg_data_i;
          CFG_VP3_X:   vp_x_q[2] <= cfg_data_i;
          CFG_VP3_Y:   vp_y_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      // begin stroke: new anchor, drop lock
      if (in_acc && action_i == ACT_BEGIN) begin
        anc_x_q <= anchor_x_i;
        anc_y_q <= anchor_y_i;
        lock_q  <= 1'b0;
      end
      // stroke point picks its direction once and holds it
      if (state_q == ST_VERT && act_q == ACT_POINT) begin
        lock_q  <= 1'b1;
        dir_x_q <= vert_take ? '0 : bux_q;
        dir_y_q <= vert_take ? UNIT_ONE : buy_q;
      end
      if (wb_load)          out_vld_q <= 1'b1;
      else if (!out_stall_i) out_vld_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          act_q  <= action_i;
          px_q   <= pos_x_i;
          py_q   <= pos_y_i;
          wa_x_q <= (action_i == ACT_POINT) ? anc_x_q : anchor_x_i;
          wa_y_q <= (action_i == ACT_POINT) ? anc_y_q : anchor_y_i;
          bux_q  <= dir_x_q;
          buy_q  <= dir_y_q;
          res_x_q <= (action_i == ACT_BEGIN) ? anchor_x_i : pos_x_i;
          res_y_q <= (action_i == ACT_BEGIN) ? anchor_y_i : pos_y_i;
        end
      end
      ST_PREP: begin
        rx_q   <= {px_q[23], px_q} - {wa_x_q[23], wa_x_q};
        ry_q   <= {py_q[23], py_q} - {wa_y_q[23], wa_y_q};
        idx_q  <= '0;
        have_q <= 1'b0;
      end
      ST_NR1, ST_CS1, ST_CR1, ST_PJ1, ST_PM1: acc_q <= prod_ext;
      ST_NR2, ST_CS2, ST_PJ2: acc_q <= acc_q + prod_ext;
      ST_NR3: begin
        if (acc_q < $signed(NEAR_SQ)) begin
          res_x_q <= wa_x_q;
          res_y_q <= wa_y_q;
        end
      end
      ST_CAND: begin
        dx_q <= {vp_sel_x[23], vp_sel_x} - {wa_x_q[23], wa_x_q};
        dy_q <= {vp_sel_y[23], vp_sel_y} - {wa_y_q[23], wa_y_q};
      end
      ST_CS3: begin
        if (acc_q < $signed(SKIP_SQ)) begin
          idx_q <= idx_q + 2'd1;
        end else begin
          sq_op_q   <= {acc_q[49:0], 14'h0000};
          sq_rem_q  <= '0;
          sq_root_q <= '0;
          cnt_q     <= '0;
          dv_y_q    <= 1'b0;
        end
      end
      ST_SQRT: begin
        sq_op_q   <= {sq_op_q[61:0], 2'b00};
        sq_rem_q  <= sq_rem_d;
        sq_root_q <= {sq_root_q[30:0], sq_ge};
        cnt_q     <= cnt_q + 5'd1;
      end
      ST_DV_INIT: begin
        dv_rem_q <= 32'(dv_num[47:18]);
        dv_sh_q  <= dv_num[17:0];
        cnt_q    <= '0;
      end
      ST_DV_RUN: begin
        dv_rem_q <= dv_rem_d;
        dv_sh_q  <= dv_q_d;
        cnt_q    <= cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) begin
          if (dv_y_q) uy_q <= dv_u;
          else        ux_q <= dv_u;
          dv_y_q <= 1'b1;
        end
      end
      ST_CR2: acc_q <= acc_q - prod_ext;
      ST_CR3: begin
        if (cr_take) begin
          best_q <= acc_mag[43:0];
          bux_q  <= ux_q;
          buy_q  <= uy_q;
        end
        have_q <= 1'b1;
        idx_q  <= idx_q + 2'd1;
      end
      ST_VERT: begin
        if (vert_take) begin
          bux_q <= '0;
          buy_q <= UNIT_ONE;
        end
      end
      ST_PJ3: begin
        tmag_q <= acc_mag[43:0];
        tneg_q <= acc_q[63];
        comp_q <= 1'b0;
      end
      ST_PM2: acc_q <= acc_q + {prod_ext[41:0], 22'h000000};
      ST_PM3: begin
        if (comp_q) res_y_q <= pm_sat;
        else        res_x_q <= pm_sat;
        comp_q <= 1'b1;
      end
      ST_WB: begin
        if (wb_load) begin
          out_x_q    <= res_x_q;
          out_y_q    <= res_y_q;
          out_lock_q <= lock_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign is_locked_o = out_lock_q;

  // divider remainder stays below the root
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DV_RUN |-> dv_rem_q < sq_root_q)
    else $error("divider remainder not below divisor");

  // root only runs for a configured point
  a_sqrt_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> idx_q < n_pts)
    else $error("root started for an unused point");

  // a held lock always has a direction
  a_lock_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lock_q |-> (dir_x_q != '0 || dir_y_q != '0))
    else $error("lock held with zero direction");

  // one-shot requests never touch the lock
  a_shot_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE && act_q == ACT_SHOT) |=> $stable(lock_q))
    else $error("one-shot request changed the lock");

  // a written result shows up as valid
  a_wb_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb_load |=> out_vld_q)
    else $error("result load lost");

endmodule
